// ===== rtl/core/cbp_pkg.sv =====
// ----------------------------------------------------------------------------
// cbp_pkg: shared types and constants of the chained bit permutation cipher
// Field widths, block geometry, input op codes and the sequencer state type.
// ----------------------------------------------------------------------------
package cbp_pkg;

    localparam int OP_W      = 2;
    localparam int TBL_AW    = 8;               // table index / entry width
    localparam int TBL_DEPTH = 1 << TBL_AW;
    localparam int WORD_W    = 64;
    localparam int BLOCK_W   = 256;             // widest block, four words
    localparam int WCNT_W    = 2;               // word slot within a block

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_LOAD_FWD   = 2'd0;
    localparam op_t OP_LOAD_CHAIN = 2'd1;
    localparam op_t OP_SEED       = 2'd2;
    localparam op_t OP_DATA       = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

endpackage

// ===== rtl/core/cbp_if.sv =====
// ----------------------------------------------------------------------------
// cbp_if: word channels of the chained bit permutation cipher
// Input channel (table loads, seed and data words) and result channel.
// ----------------------------------------------------------------------------
interface cbp_in_if
    import cbp_pkg::*;
();
    logic                valid;
    logic                ready;
    op_t                 op;
    logic [TBL_AW-1:0]   table_index;
    logic [TBL_AW-1:0]   table_entry;
    logic [WORD_W-1:0]   data_word;

    modport source (output valid, op, table_index, table_entry, data_word, input ready);
    modport sink   (input valid, op, table_index, table_entry, data_word, output ready);
endinterface

interface cbp_out_if
    import cbp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   out_word;
    logic                out_last;

    modport source (output valid, out_word, out_last, input ready);
    modport sink   (input valid, out_word, out_last, output ready);
endinterface

// ===== rtl/core/chained_bit_permutation_cipher.sv =====
// ----------------------------------------------------------------------------
// chained_bit_permutation_cipher: bit permutation cipher with block chaining
// Table memories, word gather, bit-serial permutation sequencer, result out.
// ----------------------------------------------------------------------------
// Use:
//  - item channel (valid/ready): op 0/1 write one entry of the forward or
//    chain table, op 2 and op 3 carry seed and data words of a block, word 0
//    first. The op of the word that completes a block decides: seed loads the
//    previous block, data starts a permutation.
//  - result channel (valid/ready): NWORDS words per data block, out_last on
//    the final word.
//  - cfg_we/cfg_wdata: direction, 0 encrypt, 1 decrypt. Write while idle.
// Flow:
//  - a table load or a non-final block word is taken while idle.
//  - a completed data block runs one table read per bit from each table
//    memory (single read port), with the read data registered before use.
//    Then NWORDS result words leave, one per cycle when the sink is ready.
//  - item.ready stays low from block completion until the last result word
//    is taken, so a stalled sink simply holds the block.
// Reset: previous block cleared, word slot 0, direction encrypt. Table
// contents are undefined until loaded.
// ----------------------------------------------------------------------------
module chained_bit_permutation_cipher
    import cbp_pkg::*;
#(
    parameter int BLOCK_BYTES = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_wdata,
    cbp_in_if.sink          item,
    cbp_out_if.source       result
);

    localparam int NBITS  = BLOCK_BYTES * 8;
    localparam int NWORDS = (BLOCK_BYTES + 7) / 8;
    localparam int KW     = $clog2(NBITS + 1);
    localparam logic [BLOCK_W-1:0] BLK_MASK = {BLOCK_W{1'b1}} >> (BLOCK_W - NBITS);
    localparam logic [WCNT_W-1:0]  LAST_WORD = WCNT_W'(NWORDS - 1);

    // control
    state_t              state_reg, state_next;
    logic                dir_reg;
    logic [WCNT_W-1:0]   wcnt_reg, wcnt_next;
    logic [WCNT_W-1:0]   ocnt_reg, ocnt_next;
    logic [KW-1:0]       cnt_reg, cnt_next;
    logic                rd_vld_reg;
    logic [TBL_AW-1:0]   k_reg;

    // block state
    logic [BLOCK_W-1:0]  prev_reg, prev_next;
    logic [BLOCK_W-1:0]  gat_reg, gat_upd;
    logic [BLOCK_W-1:0]  res_reg, res_next;

    // table memories
    logic [TBL_AW-1:0]   fwd_mem [TBL_DEPTH];
    logic [TBL_AW-1:0]   chn_mem [TBL_DEPTH];
    logic [TBL_AW-1:0]   fwd_q, chn_q;
    logic [TBL_AW-1:0]   rd_addr;

    logic                in_acc, out_acc;
    logic                blk_done, issue, run_end;
    logic [7:0]          wbase;
    logic                chain_bit, fwd_bit, perm_bit;

    assign in_acc  = item.valid & item.ready;
    assign out_acc = result.valid & result.ready;

    assign item.ready      = (state_reg == ST_IDLE);
    assign result.valid    = (state_reg == ST_OUT);
    assign result.out_word = res_reg[{ocnt_reg, 6'b0} +: WORD_W];
    assign result.out_last = (ocnt_reg == LAST_WORD);

    // word gather, masked above the block
    assign wbase    = {wcnt_reg, 6'b0};
    assign blk_done = in_acc && (item.op == OP_SEED || item.op == OP_DATA)
                      && (wcnt_reg == LAST_WORD);

    always_comb
    begin
        gat_upd = gat_reg;
        gat_upd[wbase +: WORD_W] = item.data_word & BLK_MASK[wbase +: WORD_W];
    end

    // sequencer: issue address k, use table data in the following cycle
    assign issue   = (state_reg == ST_RUN) && (cnt_reg < KW'(NBITS));
    assign run_end = (state_reg == ST_RUN) && (cnt_reg == KW'(NBITS));
    assign rd_addr = TBL_AW'(cnt_reg);

    // table memories: load port and sequencer read port
    always_ff @(posedge clk)
    begin
        if (in_acc && item.op == OP_LOAD_FWD)
            fwd_mem[item.table_index] <= item.table_entry;
        fwd_q <= fwd_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && item.op == OP_LOAD_CHAIN)
            chn_mem[item.table_index] <= item.table_entry;
        chn_q <= chn_mem[rd_addr];
    end

    // one bit per cycle; sources outside the block read zero
    assign chain_bit = ({1'b0, chn_q} < (TBL_AW+1)'(NBITS)) ? prev_reg[chn_q] : 1'b0;
    assign fwd_bit   = ({1'b0, fwd_q} < (TBL_AW+1)'(NBITS)) ? gat_reg[fwd_q] : 1'b0;

    always_comb
    begin
        res_next = res_reg;
        perm_bit = 1'b0;
        if (rd_vld_reg)
        begin
            if (!dir_reg)
            begin
                perm_bit = fwd_bit ^ chain_bit;
                res_next[k_reg] = perm_bit;
            end
            else
            begin
                // scatter: later positions overwrite earlier ones
                perm_bit = gat_reg[k_reg] ^ chain_bit;
                if ({1'b0, fwd_q} < (TBL_AW+1)'(NBITS))
                    res_next[fwd_q] = perm_bit;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        wcnt_next  = wcnt_reg;
        ocnt_next  = ocnt_reg;
        cnt_next   = cnt_reg;
        prev_next  = prev_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (item.op == OP_SEED || item.op == OP_DATA))
                    wcnt_next = blk_done ? '0 : wcnt_reg + 1'b1;
                if (blk_done && item.op == OP_SEED)
                    prev_next = gat_upd;
                if (blk_done && item.op == OP_DATA)
                begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (issue)
                    cnt_next = cnt_reg + 1'b1;
                if (run_end)
                begin
                    prev_next  = dir_reg ? gat_reg : res_next;
                    state_next = ST_OUT;
                    ocnt_next  = '0;
                end
            end
            ST_OUT:
            begin
                if (out_acc)
                begin
                    ocnt_next = ocnt_reg + 1'b1;
                    if (ocnt_reg == LAST_WORD)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            dir_reg    <= 1'b0;
            wcnt_reg   <= '0;
            ocnt_reg   <= '0;
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
            prev_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            wcnt_reg   <= wcnt_next;
            ocnt_reg   <= ocnt_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= issue;
            prev_reg   <= prev_next;
            if (cfg_we)
                dir_reg <= cfg_wdata;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        k_reg <= rd_addr;
        if (in_acc && (item.op == OP_SEED || item.op == OP_DATA))
            gat_reg <= gat_upd;
        if (blk_done && item.op == OP_DATA)
            res_reg <= '0;
        else if (state_reg == ST_RUN)
            res_reg <= res_next;
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(item.ready && result.valid))
        else $error("input and result sides open at once");

    a_run_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        run_end |=> (state_reg == ST_OUT))
        else $error("permutation end did not raise the result");

    a_rd_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == ST_RUN))
        else $error("table read data outside a permutation run");

    a_wcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        wcnt_reg <= LAST_WORD)
        else $error("word slot beyond the block");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> $stable(res_reg))
        else $error("result block changed while stalled");
`endif

endmodule

// ===== verif/chained_bit_permutation_cipher_tb.sv =====
// ----------------------------------------------------------------------------
// chained_bit_permutation_cipher_tb: self-checking bench of the chaining cipher
// Loads both bit tables, runs directed and random seed and data words in both
// directions under random handshake gaps, and checks every result word against
// a bench-side model of the permutation and the chaining.
// ----------------------------------------------------------------------------
module chained_bit_permutation_cipher_tb
    import cbp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLOCK_BYTES = 32;
    localparam int NBITS       = BLOCK_BYTES * 8;
    localparam int NWORDS      = (BLOCK_BYTES + 7) / 8;
    // A block runs its permutation with no handshake at all; stalls on the
    // result side add to that. Several times the slowest honest gap.
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE      = 8;

    typedef enum int { FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_ALT } fill_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } result_word_t;

    // ------------------------------------------------------------------------
    // Tracker: own copy of tables, chaining state and direction. Each accepted
    // word updates it; a completed data block queues the words it must yield.
    // ------------------------------------------------------------------------
    class cipher_tracker;
        logic [TBL_AW-1:0]  fwd_tbl [TBL_DEPTH];
        logic [TBL_AW-1:0]  chn_tbl [TBL_DEPTH];
        logic [BLOCK_W-1:0] prev_blk;
        logic [BLOCK_W-1:0] gather;
        int unsigned        slot;
        logic               decrypt;
        result_word_t       expected_words [$];
        int                 failures;
        int                 n_enc;
        int                 n_dec;
        int                 n_seed;
        int                 n_loads;
        int                 n_words;

        function new();
            foreach (fwd_tbl[i])
            begin
                fwd_tbl[i] = '0;
                chn_tbl[i] = '0;
            end
            prev_blk = '0;
            gather   = '0;
            slot     = 0;
            decrypt  = 1'b0;
            failures = 0;
            n_enc    = 0;
            n_dec    = 0;
            n_seed   = 0;
            n_loads  = 0;
            n_words  = 0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10)
                $display("%0d ns: MISMATCH %s", $time, msg);
        endfunction

        // bits beyond the block read as zero
        function logic bit_at(logic [BLOCK_W-1:0] b, int k);
            if (k >= NBITS)
                return 1'b0;
            return b[k];
        endfunction

        function logic [WORD_W-1:0] mask_of(int w);
            int rem;
            rem = NBITS - WORD_W * w;
            if (rem >= WORD_W)
                return '1;
            return (64'd1 << rem) - 64'd1;
        endfunction

        function void finish_block();
            logic [BLOCK_W-1:0] res;
            logic               t;
            int                 k;
            res = '0;
            for (k = 0; k < NBITS; k++)
            begin
                if (!decrypt)
                    res[k] = bit_at(gather, int'(fwd_tbl[k])) ^
                             bit_at(prev_blk, int'(chn_tbl[k]));
                else
                begin
                    // scatter: ascending k, so the higher position wins a clash
                    t = gather[k] ^ bit_at(prev_blk, int'(chn_tbl[k]));
                    if (fwd_tbl[k] < NBITS)
                        res[fwd_tbl[k]] = t;
                end
            end
            if (!decrypt)
            begin
                prev_blk = res;
                n_enc++;
            end
            else
            begin
                prev_blk = gather;
                n_dec++;
            end
            for (k = 0; k < NWORDS; k++)
                expected_words.push_back('{word: res[WORD_W*k +: WORD_W],
                                           last: (k == NWORDS - 1)});
        endfunction

        function void note_item(op_t op, logic [TBL_AW-1:0] idx,
                                logic [TBL_AW-1:0] ent, logic [WORD_W-1:0] dw);
            case (op)
                OP_LOAD_FWD:
                begin
                    fwd_tbl[idx] = ent;
                    n_loads++;
                end
                OP_LOAD_CHAIN:
                begin
                    chn_tbl[idx] = ent;
                    n_loads++;
                end
                default:
                begin
                    gather[WORD_W*slot +: WORD_W] = dw & mask_of(int'(slot));
                    if (slot + 1 < NWORDS)
                        slot++;
                    else
                    begin
                        // op of the completing word decides
                        slot = 0;
                        if (op == OP_SEED)
                        begin
                            prev_blk = gather;
                            n_seed++;
                        end
                        else
                            finish_block();
                    end
                end
            endcase
        endfunction

        function void check_word(logic [WORD_W-1:0] word, logic last);
            result_word_t want;
            if (expected_words.size() == 0)
            begin
                flag($sformatf("unexpected word %h last %b", word, last));
                return;
            end
            want = expected_words.pop_front();
            n_words++;
            if (word !== want.word)
                flag($sformatf("out_word expected %h actual %h", want.word, word));
            if (last !== want.last)
                flag($sformatf("out_last expected %b actual %b", want.last, last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block and channels
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    cbp_in_if  item_ch ();
    cbp_out_if result_ch ();

    chained_bit_permutation_cipher #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (result_ch)
    );

    cipher_tracker tracker;

    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int stall_cycles;
    int unsigned gen_slot;      // word slot as seen by the stimulus side
    logic [TBL_AW-1:0] fwd_shadow [TBL_DEPTH];
    logic [TBL_AW-1:0] chn_shadow [TBL_DEPTH];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side: ready redrawn every falling edge.
    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Sample handshakes and the register write on the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
                tracker.check_word(result_ch.out_word, result_ch.out_last);
            if (item_ch.valid && item_ch.ready)
                tracker.note_item(item_ch.op, item_ch.table_index,
                                  item_ch.table_entry, item_ch.data_word);
            if (cfg_we)
                tracker.decrypt = cfg_wdata;
        end
    end

    // Watchdog: too long without any word moving on either channel.
    initial
    begin
        stall_cycles = 0;
        @(posedge rst_n);
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("%0d ns: no handshake for %0d cycles, %0d words outstanding",
                 $time, STALL_LIMIT, tracker.pending());
        $display("chained_bit_permutation_cipher_tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------
    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // One word onto the item channel; random gap first, then hold until taken.
    task automatic send_item(op_t op, logic [TBL_AW-1:0] idx,
                             logic [TBL_AW-1:0] ent, logic [WORD_W-1:0] dw);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.op          <= op;
        item_ch.table_index <= idx;
        item_ch.table_entry <= ent;
        item_ch.data_word   <= dw;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic load_entry(op_t tbl, logic [TBL_AW-1:0] idx, logic [TBL_AW-1:0] ent);
        if (tbl == OP_LOAD_FWD)
            fwd_shadow[idx] = ent;
        else
            chn_shadow[idx] = ent;
        // data_word is don't-care on loads: drive noise
        send_item(tbl, idx, ent, rand_word());
    endtask

    // Swap two positions: a permutation stays a permutation.
    task automatic swap_entries(op_t tbl);
        logic [TBL_AW-1:0] i;
        logic [TBL_AW-1:0] j;
        logic [TBL_AW-1:0] a;
        logic [TBL_AW-1:0] b;
        i = TBL_AW'($urandom_range(TBL_DEPTH - 1));
        j = TBL_AW'($urandom_range(TBL_DEPTH - 1));
        a = (tbl == OP_LOAD_FWD) ? fwd_shadow[i] : chn_shadow[i];
        b = (tbl == OP_LOAD_FWD) ? fwd_shadow[j] : chn_shadow[j];
        load_entry(tbl, i, b);
        load_entry(tbl, j, a);
    endtask

    task automatic send_block_word(op_t op, logic [WORD_W-1:0] dw);
        send_item(op, TBL_AW'($urandom_range(TBL_DEPTH - 1)),
                  TBL_AW'($urandom_range(TBL_DEPTH - 1)), dw);
        gen_slot = (gen_slot + 1) % NWORDS;
    endtask

    // Complete the block being gathered. Earlier words may mix seed and data
    // ops; a table swap may fall between words.
    task automatic send_block(op_t final_op, bit mixed, bit with_swap, fill_t fill);
        logic [WORD_W-1:0] dw;
        op_t               op;
        int                w;
        for (w = int'(gen_slot); w < NWORDS; w++)
        begin
            case (fill)
                FILL_ZERO: dw = '0;
                FILL_ONES: dw = '1;
                FILL_ALT:  dw = {32{2'b10}};
                default:   dw = rand_word();
            endcase
            if (w == NWORDS - 1 || !mixed)
                op = final_op;
            else
                op = $urandom_range(1) ? OP_DATA : OP_SEED;
            if (with_swap && w == 1)
                swap_entries($urandom_range(1) ? OP_LOAD_FWD : OP_LOAD_CHAIN);
            send_block_word(op, dw);
        end
    endtask

    // Hold the sender off until every expected word has come back.
    task automatic wait_for_results();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_direction(logic d);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= d;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(int n_items);
        int first;
        int pick;
        first = items_sent;
        wait_for_results();
        while (items_sent - first < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                send_block(OP_DATA, 1'b0, 1'b0, FILL_RANDOM);
            else if (pick < 55)
                send_block(OP_DATA, 1'b1, 1'($urandom_range(1)), FILL_RANDOM);
            else if (pick < 63)
                send_block(OP_SEED, 1'($urandom_range(1)), 1'b0, FILL_RANDOM);
            else if (pick < 76)
                swap_entries($urandom_range(1) ? OP_LOAD_FWD : OP_LOAD_CHAIN);
            else if (pick < 83)
            begin
                // broken block: a few words, finished by whatever comes next
                repeat ($urandom_range(1, NWORDS - 1))
                    send_block_word($urandom_range(1) ? OP_DATA : OP_SEED, rand_word());
            end
            else if (pick < 87)
            begin
                // stray write: table no longer a permutation
                if ($urandom_range(1))
                    load_entry(OP_LOAD_FWD, TBL_AW'($urandom_range(TBL_DEPTH - 1)),
                               TBL_AW'($urandom_range(TBL_DEPTH - 1)));
                else
                    load_entry(OP_LOAD_CHAIN, TBL_AW'($urandom_range(TBL_DEPTH - 1)),
                               TBL_AW'($urandom_range(TBL_DEPTH - 1)));
            end
            else if (pick < 93)
                write_direction(1'($urandom_range(1)));
            else if (pick < 96)
                wait_for_results();
            else
                send_block(OP_DATA, 1'b0, 1'b0, fill_t'($urandom_range(3)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [TBL_AW-1:0] saved_fwd;
        logic [TBL_AW-1:0] saved_chn;
        logic [TBL_AW-1:0] tmp;
        int                i;
        int                j;

        item_ch.valid       = 1'b0;
        item_ch.op          = OP_LOAD_FWD;
        item_ch.table_index = '0;
        item_ch.table_entry = '0;
        item_ch.data_word   = '0;
        cfg_we              = 1'b0;
        cfg_wdata           = 1'b0;
        rst_n               = 1'b0;
        tracker             = new();
        items_sent          = 0;
        gen_slot            = 0;
        send_idle_pct       = 36;
        recv_idle_pct       = 85;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Every table entry is written before the first block completes:
        // forward a random permutation, chain the bit reversal.
        for (i = 0; i < TBL_DEPTH; i++)
            fwd_shadow[i] = TBL_AW'(i);
        for (i = TBL_DEPTH - 1; i > 0; i--)
        begin
            j             = $urandom_range(i);
            tmp           = fwd_shadow[i];
            fwd_shadow[i] = fwd_shadow[j];
            fwd_shadow[j] = tmp;
        end
        for (i = 0; i < TBL_DEPTH; i++)
            load_entry(OP_LOAD_FWD, TBL_AW'(i), fwd_shadow[i]);
        for (i = 0; i < TBL_DEPTH; i++)
            load_entry(OP_LOAD_CHAIN, TBL_AW'(i), TBL_AW'(TBL_DEPTH - 1 - i));

        // --- directed part ---
        // data extremes straight after reset, previous block still zero
        send_block(OP_DATA, 1'b0, 1'b0, FILL_ZERO);
        send_block(OP_DATA, 1'b0, 1'b0, FILL_ONES);
        // mixed ops ending in a seed word: block becomes the previous block
        send_block(OP_SEED, 1'b1, 1'b0, FILL_ALT);
        // mixed ops ending in data, a table swap between words
        send_block(OP_DATA, 1'b1, 1'b1, FILL_RANDOM);
        // decrypt chaining
        write_direction(1'b1);
        send_block(OP_DATA, 1'b0, 1'b0, FILL_ONES);
        // direction changed half way through a gather: taken at completion
        send_block_word(OP_DATA, rand_word());
        send_block_word(OP_DATA, rand_word());
        write_direction(1'b0);
        send_block(OP_DATA, 1'b0, 1'b0, FILL_RANDOM);
        // clashing forward entries and a chain entry at the extreme position
        saved_fwd = fwd_shadow[20];
        saved_chn = chn_shadow[TBL_DEPTH - 1];
        load_entry(OP_LOAD_FWD, TBL_AW'(20), fwd_shadow[10]);
        load_entry(OP_LOAD_CHAIN, TBL_AW'(TBL_DEPTH - 1), '0);
        send_block(OP_DATA, 1'b0, 1'b0, FILL_ONES);
        write_direction(1'b1);
        send_block(OP_DATA, 1'b0, 1'b0, FILL_ONES);
        load_entry(OP_LOAD_FWD, TBL_AW'(20), saved_fwd);
        load_entry(OP_LOAD_CHAIN, TBL_AW'(TBL_DEPTH - 1), saved_chn);
        write_direction(1'b0);

        // --- random part, three handshake regimes ---
        random_phase(157);
        send_idle_pct = 85;
        recv_idle_pct = 36;
        random_phase(157);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(157);

        // finish any half-gathered block so the last words are checked too
        if (gen_slot != 0)
            send_block(OP_DATA, 1'b0, 1'b0, FILL_RANDOM);

        // drain: watchdog covers a hang here
        wait_for_results();
        repeat (4 * NBITS) @(negedge clk);

        $display("run covered %0d items: %0d table writes, %0d seed blocks,",
                 items_sent, tracker.n_loads, tracker.n_seed);
        $display("%0d encrypt and %0d decrypt blocks, %0d result words, %0d mismatches",
                 tracker.n_enc, tracker.n_dec, tracker.n_words, tracker.failures);
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("chained_bit_permutation_cipher_tb: done, clean");
        else
            $display("chained_bit_permutation_cipher_tb: done, errors");
        $finish;
    end

endmodule
